/* rtl/slqe_pkg.sv */
// Shared types and constants of the soft line quad expander.
// No dependencies; the top level and slqe_iter import it.
package slqe_pkg;

	localparam int CNT_W        = 14;
	localparam int MAX_VERTICES = 8192;

	localparam logic [CNT_W-1:0] VERTS_HARD = CNT_W'(6);
	localparam logic [CNT_W-1:0] VERTS_SOFT = CNT_W'(18);

	localparam logic [15:0] OUTER_GAIN = 16'd22938;
	localparam logic [15:0] RATIO_MAX  = 16'd62259;
	localparam logic [15:0] RATIO_HARD = 16'd65;
	localparam logic [15:0] ALPHA_MIN  = 16'd4;
	localparam logic [31:0] STEEP_K    = 32'd99999999;
	localparam logic [15:0] GAIN_RESET = 16'd4096;

	// register index, taken from paddr[2]
	localparam logic REG_SOFT_RATIO = 1'b0;
	localparam logic REG_CORE_GAIN  = 1'b1;

	typedef enum logic {
		IT_DIV  = 1'b0,
		IT_SQRT = 1'b1
	} iter_mode_t;

	typedef struct packed {
		logic       start;
		iter_mode_t mode;
	} iter_cmd_t;

	typedef enum logic [1:0] {
		OFS_NEG_HALF = 2'd0,
		OFS_NEG_CORE = 2'd1,
		OFS_POS_CORE = 2'd2,
		OFS_POS_HALF = 2'd3
	} ofs_sel_t;

	typedef enum logic {
		COL_CORE  = 1'b0,
		COL_OUTER = 1'b1
	} col_sel_t;

	typedef enum logic [1:0] {
		STRIP_HARD = 2'd0,
		STRIP_S0   = 2'd1,
		STRIP_S1   = 2'd2,
		STRIP_S2   = 2'd3
	} strip_t;

endpackage

/* rtl/soft_line_quad_expander.sv */
// Top level of the soft line quad expander: sequencer, registers, vertex output.
// Uses slqe_pkg, slqe_mul (shared multiplier) and slqe_iter (sqrt / divide).
//
// Channel  | Handshake                     | Direction | Content
// ---------+-------------------------------+-----------+-------------------------------
// input    | in_valid / in_stall           | in        | one segment per transfer
// output   | out_valid / out_stall         | out       | one vertex per transfer
// config   | psel penable pwrite pready    | in        | soft_edge_ratio, core_intensity
//
// Before its first vertex a segment goes through the sequence of multiplies on
// the shared multiplier (one per cycle), a one-bit-per-cycle normalizing shift,
// a 32-step square root and two 31-step divisions in slqe_iter. Then 6 or 18
// vertices leave at one per cycle while out_stall is low.
// Dropped segments return to idle from S_PREP or S_CMP.
// in_stall is high from acceptance until the last vertex is loaded into the
// output register; out_stall only holds that register and the emission step.
// Reset clears control state and the vertex count, clears ratio and sets gain to GAIN_RESET.
module soft_line_quad_expander (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        frame_start,
	input  logic [31:0] start_x,
	input  logic [31:0] start_y,
	input  logic [31:0] start_z,
	input  logic [31:0] end_x,
	input  logic [31:0] end_y,
	input  logic [31:0] end_z,
	input  logic [31:0] line_width,
	input  logic [15:0] red,
	input  logic [15:0] green,
	input  logic [15:0] blue,
	input  logic [15:0] alpha,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] vertex_x,
	output logic [31:0] vertex_y,
	output logic [31:0] vertex_z,
	output logic [15:0] out_red,
	output logic [15:0] out_green,
	output logic [15:0] out_blue,
	output logic [15:0] out_alpha,
	output logic        tex_u,
	output logic        tex_v,
	output logic        last_vertex,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import slqe_pkg::*;

	typedef enum logic [16:0] {
		S_IDLE  = 17'h00001,
		S_PREP  = 17'h00002,
		S_MULA  = 17'h00004,
		S_STEEP = 17'h00008,
		S_MULB  = 17'h00010,
		S_CMP   = 17'h00020,
		S_NORM  = 17'h00040,
		S_MULC  = 17'h00080,
		S_RT_GO = 17'h00100,
		S_RT_WT = 17'h00200,
		S_DX_GO = 17'h00400,
		S_DX_WT = 17'h00800,
		S_DY_GO = 17'h01000,
		S_DY_WT = 17'h02000,
		S_MULD  = 17'h04000,
		S_MULE  = 17'h08000,
		S_EMIT  = 17'h10000
	} state_t;

	state_t state_q, state_d;
	logic [3:0] step_q;

	// ---------------- config registers ----------------
	logic [15:0] ratio_q, gain_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= '0;
			gain_q  <= GAIN_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_SOFT_RATIO) begin
				ratio_q <= pwdata[15:0];
			end else begin
				gain_q <= pwdata[15:0];
			end
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SOFT_RATIO: prdata = {16'b0, ratio_q};
			REG_CORE_GAIN:  prdata = {16'b0, gain_q};
			default:        prdata = '0;
		endcase
	end

	// ---------------- segment registers ----------------
	logic        in_acc;
	logic [31:0] sx_q, sy_q, sz_q, ex_q, ey_q, ez_q, width_q;
	logic [15:0] red_q, grn_q, blu_q, alp_q;
	logic [CNT_W-1:0] vcount_q;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid & ~in_stall;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sx_q    <= start_x;
			sy_q    <= start_y;
			sz_q    <= start_z;
			ex_q    <= end_x;
			ey_q    <= end_y;
			ez_q    <= end_z;
			width_q <= line_width;
			red_q   <= red;
			grn_q   <= green;
			blu_q   <= blue;
			alp_q   <= alpha;
		end
	end

	// ---------------- prep: deltas and early drops ----------------
	logic signed [32:0] dx, dy, dz;
	logic [31:0] ax, ay, az;
	logic [15:0] ratio_c;
	logic [8:0]  short_sum;
	logic        is_short, drop;

	always_comb begin
		dx = $signed({ex_q[31], ex_q}) - $signed({sx_q[31], sx_q});
		dy = $signed({ey_q[31], ey_q}) - $signed({sy_q[31], sy_q});
		dz = $signed({ez_q[31], ez_q}) - $signed({sz_q[31], sz_q});
		ax = dx[32] ? 32'(-dx) : dx[31:0];
		ay = dy[32] ? 32'(-dy) : dy[31:0];
		az = dz[32] ? 32'(-dz) : dz[31:0];
		short_sum = 9'({6'b0, ax[2:0]} * {6'b0, ax[2:0]})
			+ 9'({6'b0, ay[2:0]} * {6'b0, ay[2:0]})
			+ 9'({6'b0, az[2:0]} * {6'b0, az[2:0]});
		is_short = (ax <= 32'd6) && (ay <= 32'd6) && (az <= 32'd6) && (short_sum <= 9'd42);
		drop = (alp_q <= ALPHA_MIN) || ($signed(width_q) <= 0)
			|| (({1'b0, vcount_q} + {1'b0, VERTS_SOFT}) > (CNT_W + 1)'(MAX_VERTICES))
			|| is_short;
		ratio_c = (ratio_q > RATIO_MAX) ? RATIO_MAX : ratio_q;
	end

	logic [31:0] ax_q, ay_q, az_q, ux_q, uy_q;
	logic        nxn_q, nyn_q, hard_q;

	// ---------------- shared multiplier ----------------
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;

	slqe_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	logic [63:0] sqx_q, sqy_q, dz2_q, phi_q, plo_q;
	logic [37:0] lxy_q;
	logic [31:0] root_q;
	logic [30:0] nxm_q, nym_q, ch_q;
	logic [15:0] cr_q, cg_q, cb_q, or_q, og_q, ob_q;
	logic signed [31:0] ohx_q, ohy_q, ocx_q, ocy_q;
	logic [16:0] inv_ratio;

	assign inv_ratio = 17'h10000 - {1'b0, ratio_c};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MULA: begin
				case (step_q)
					4'd0:    begin mul_a = ax_q; mul_b = ax_q; end
					4'd1:    begin mul_a = ay_q; mul_b = ay_q; end
					default: begin mul_a = az_q; mul_b = az_q; end
				endcase
			end
			S_MULB: begin
				mul_a = (step_q == 4'd0) ? {13'b0, lxy_q[37:19]} : {13'b0, lxy_q[18:0]};
				mul_b = STEEP_K;
			end
			S_MULC: begin
				mul_a = (step_q == 4'd0) ? ux_q : uy_q;
				mul_b = mul_a;
			end
			S_MULD: begin
				case (step_q)
					4'd0: begin mul_a = {1'b0, width_q[30:0]}; mul_b = {15'b0, inv_ratio}; end
					4'd1: begin mul_a = {16'b0, red_q}; mul_b = {16'b0, gain_q}; end
					4'd2: begin mul_a = {16'b0, grn_q}; mul_b = {16'b0, gain_q}; end
					4'd3: begin mul_a = {16'b0, blu_q}; mul_b = {16'b0, gain_q}; end
					4'd4: begin mul_a = {16'b0, red_q}; mul_b = {16'b0, OUTER_GAIN}; end
					4'd5: begin mul_a = {16'b0, grn_q}; mul_b = {16'b0, OUTER_GAIN}; end
					default: begin mul_a = {16'b0, blu_q}; mul_b = {16'b0, OUTER_GAIN}; end
				endcase
			end
			S_MULE: begin
				case (step_q)
					4'd0: begin mul_a = {1'b0, nxm_q}; mul_b = {1'b0, width_q[30:0]}; end
					4'd1: begin mul_a = {1'b0, nym_q}; mul_b = {1'b0, width_q[30:0]}; end
					4'd2: begin mul_a = {1'b0, nxm_q}; mul_b = {1'b0, ch_q}; end
					default: begin mul_a = {1'b0, nym_q}; mul_b = {1'b0, ch_q}; end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// rounded products for capture
	logic [47:0] ch_rnd;
	logic [32:0] core_rnd;
	logic [20:0] core_v;
	logic [15:0] core_sat;
	logic [31:0] outer_rnd;
	logic [62:0] ofs_rnd;
	logic [31:0] ofs_mag;

	always_comb begin
		ch_rnd    = mul_p[47:0] + 48'h8000;
		core_rnd  = {1'b0, mul_p[31:0]} + 33'd2048;
		core_v    = core_rnd[32:12];
		core_sat  = (core_v[20:16] != 5'd0) ? 16'hFFFF : core_v[15:0];
		outer_rnd = mul_p[31:0] + 32'h8000;
		ofs_rnd   = mul_p[62:0] + {32'b0, 1'b1, 30'b0};
		ofs_mag   = ofs_rnd[62:31];
	end

	// ---------------- steep test and normalization ----------------
	logic [64:0] lxy_full;
	logic [65:0] steep_t;
	logic        lxy_big, is_steep;
	logic [31:0] norm_m;
	logic        norm_done;

	always_comb begin
		lxy_full  = {1'b0, sqx_q} + {1'b0, sqy_q};
		lxy_big   = (lxy_full[64:38] != '0);
		steep_t   = {phi_q[46:0], 19'b0} + {2'b0, plo_q};
		is_steep  = (steep_t <= {2'b0, dz2_q});
		norm_m    = (ux_q > uy_q) ? ux_q : uy_q;
		norm_done = ~norm_m[31] & norm_m[30];
	end

	// ---------------- iterative sqrt / divide ----------------
	iter_cmd_t   it_cmd;
	logic [63:0] it_opnd;
	logic [61:0] div_d;
	logic        it_done;
	logic [31:0] it_res;

	always_comb begin
		it_cmd.start = (state_q == S_RT_GO) || (state_q == S_DX_GO) || (state_q == S_DY_GO);
		it_cmd.mode  = (state_q == S_RT_GO) ? IT_SQRT : IT_DIV;
		// normal x comes from |dy|, normal y from |dx|
		div_d = {1'b0, ((state_q == S_DX_GO) ? uy_q[30:0] : ux_q[30:0]), 30'b0}
			+ {31'b0, root_q[31:1]};
		it_opnd = (state_q == S_RT_GO) ? (sqx_q + sqy_q) : {2'b0, div_d};
	end

	slqe_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (it_cmd),
		.opnd   (it_opnd),
		.dvs    (root_q),
		.done   (it_done),
		.res    (it_res)
	);

	// ---------------- vertex emission ----------------
	strip_t     strip_q;
	logic [2:0] vi_q;
	logic       emit_load, emit_last;
	logic       v_end, v_hi;
	ofs_sel_t   o0, o1, osel;
	col_sel_t   c0, c1, csel;
	logic signed [31:0] ox, oy;
	logic [31:0] bx, by, bz;
	logic [32:0] px, py;
	logic [31:0] vx, vy;
	logic        out_valid_q;

	always_comb begin
		case (strip_q)
			STRIP_HARD: begin o0 = OFS_NEG_HALF; o1 = OFS_POS_HALF; c0 = COL_CORE;  c1 = COL_CORE;  end
			STRIP_S0:   begin o0 = OFS_NEG_HALF; o1 = OFS_NEG_CORE; c0 = COL_OUTER; c1 = COL_CORE;  end
			STRIP_S1:   begin o0 = OFS_NEG_CORE; o1 = OFS_POS_CORE; c0 = COL_CORE;  c1 = COL_CORE;  end
			default:    begin o0 = OFS_POS_CORE; o1 = OFS_POS_HALF; c0 = COL_CORE;  c1 = COL_OUTER; end
		endcase
		// triangle order per strip: s0 s1 e0 / s1 e1 e0
		v_end = (vi_q == 3'd2) || (vi_q == 3'd4) || (vi_q == 3'd5);
		v_hi  = (vi_q == 3'd1) || (vi_q == 3'd3) || (vi_q == 3'd4);
		osel  = v_hi ? o1 : o0;
		csel  = v_hi ? c1 : c0;
		case (osel)
			OFS_NEG_HALF: begin ox = -ohx_q; oy = -ohy_q; end
			OFS_NEG_CORE: begin ox = -ocx_q; oy = -ocy_q; end
			OFS_POS_CORE: begin ox = ocx_q;  oy = ocy_q;  end
			default:      begin ox = ohx_q;  oy = ohy_q;  end
		endcase
		bx = v_end ? ex_q : sx_q;
		by = v_end ? ey_q : sy_q;
		bz = v_end ? ez_q : sz_q;
		px = {bx[31], bx} + {ox[31], ox};
		py = {by[31], by} + {oy[31], oy};
		vx = (px[32] != px[31]) ? (px[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : px[31:0];
		vy = (py[32] != py[31]) ? (py[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : py[31:0];
		emit_load = (state_q == S_EMIT) && (~out_valid_q || ~out_stall);
		emit_last = (vi_q == 3'd5) && ((strip_q == STRIP_HARD) || (strip_q == STRIP_S2));
	end

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_acc) state_d = S_PREP;
			S_PREP:  state_d = drop ? S_IDLE : S_MULA;
			S_MULA:  if (step_q == 4'd3) state_d = S_STEEP;
			S_STEEP: state_d = lxy_big ? S_NORM : S_MULB;
			S_MULB:  if (step_q == 4'd2) state_d = S_CMP;
			S_CMP:   state_d = is_steep ? S_IDLE : S_NORM;
			S_NORM:  if (norm_done) state_d = S_MULC;
			S_MULC:  if (step_q == 4'd2) state_d = S_RT_GO;
			S_RT_GO: state_d = S_RT_WT;
			S_RT_WT: if (it_done) state_d = S_DX_GO;
			S_DX_GO: state_d = S_DX_WT;
			S_DX_WT: if (it_done) state_d = S_DY_GO;
			S_DY_GO: state_d = S_DY_WT;
			S_DY_WT: if (it_done) state_d = S_MULD;
			S_MULD:  if (step_q == 4'd7) state_d = S_MULE;
			S_MULE:  if (step_q == 4'd4) state_d = S_EMIT;
			S_EMIT:  if (emit_load && emit_last) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			vcount_q    <= '0;
			out_valid_q <= 1'b0;
			strip_q     <= STRIP_HARD;
			vi_q        <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= (state_d != state_q) ? 4'd0 : step_q + 4'd1;

			if (in_acc && frame_start) begin
				vcount_q <= '0;
			end else if (state_q == S_MULE && step_q == 4'd4) begin
				vcount_q <= vcount_q + (hard_q ? VERTS_HARD : VERTS_SOFT);
			end

			if (state_q == S_MULE && step_q == 4'd4) begin
				strip_q <= hard_q ? STRIP_HARD : STRIP_S0;
				vi_q    <= '0;
			end else if (emit_load) begin
				if (vi_q == 3'd5) begin
					vi_q <= '0;
					case (strip_q)
						STRIP_S0: strip_q <= STRIP_S1;
						STRIP_S1: strip_q <= STRIP_S2;
						default:  strip_q <= strip_q;
					endcase
				end else begin
					vi_q <= vi_q + 3'd1;
				end
			end

			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (~out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- datapath captures ----------------
	always_ff @(posedge clk) begin
		if (state_q == S_PREP) begin
			ax_q   <= ax;
			ay_q   <= ay;
			az_q   <= az;
			ux_q   <= ax;
			uy_q   <= ay;
			nxn_q  <= ~dy[32] && (dy != '0);
			nyn_q  <= dx[32];
			hard_q <= (ratio_c <= RATIO_HARD);
		end
		if (state_q == S_MULA) begin
			if (step_q == 4'd1) sqx_q <= mul_p;
			if (step_q == 4'd2) sqy_q <= mul_p;
			if (step_q == 4'd3) dz2_q <= mul_p;
		end
		if (state_q == S_STEEP) begin
			lxy_q <= lxy_full[37:0];
		end
		if (state_q == S_MULB) begin
			if (step_q == 4'd1) phi_q <= mul_p;
			if (step_q == 4'd2) plo_q <= mul_p;
		end
		if (state_q == S_NORM && !norm_done) begin
			if (norm_m[31]) begin
				ux_q <= {1'b0, ux_q[31:1]};
				uy_q <= {1'b0, uy_q[31:1]};
			end else begin
				ux_q <= {ux_q[30:0], 1'b0};
				uy_q <= {uy_q[30:0], 1'b0};
			end
		end
		if (state_q == S_MULC) begin
			if (step_q == 4'd1) sqx_q <= mul_p;
			if (step_q == 4'd2) sqy_q <= mul_p;
		end
		if (state_q == S_RT_WT && it_done) root_q <= it_res;
		if (state_q == S_DX_WT && it_done) nxm_q <= it_res[30:0];
		if (state_q == S_DY_WT && it_done) nym_q <= it_res[30:0];
		if (state_q == S_MULD) begin
			case (step_q)
				4'd1: ch_q <= ch_rnd[46:16];
				4'd2: cr_q <= core_sat;
				4'd3: cg_q <= core_sat;
				4'd4: cb_q <= core_sat;
				4'd5: or_q <= outer_rnd[31:16];
				4'd6: og_q <= outer_rnd[31:16];
				4'd7: ob_q <= outer_rnd[31:16];
				default: ;
			endcase
		end
		if (state_q == S_MULE) begin
			case (step_q)
				4'd1: ohx_q <= nxn_q ? -$signed(ofs_mag) : $signed(ofs_mag);
				4'd2: ohy_q <= nyn_q ? -$signed(ofs_mag) : $signed(ofs_mag);
				4'd3: ocx_q <= nxn_q ? -$signed(ofs_mag) : $signed(ofs_mag);
				4'd4: ocy_q <= nyn_q ? -$signed(ofs_mag) : $signed(ofs_mag);
				default: ;
			endcase
		end
	end

	// ---------------- output register ----------------
	logic [31:0] vx_q, vy_q, vz_q;
	logic [15:0] or_out_q, og_out_q, ob_out_q, oa_out_q;
	logic        u_q, v_q, last_q;

	always_ff @(posedge clk) begin
		if (emit_load) begin
			vx_q     <= vx;
			vy_q     <= vy;
			vz_q     <= bz;
			or_out_q <= (csel == COL_OUTER) ? or_q : cr_q;
			og_out_q <= (csel == COL_OUTER) ? og_q : cg_q;
			ob_out_q <= (csel == COL_OUTER) ? ob_q : cb_q;
			oa_out_q <= (csel == COL_OUTER) ? 16'd0 : alp_q;
			u_q      <= v_end;
			v_q      <= v_hi;
			last_q   <= emit_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign vertex_x    = vx_q;
	assign vertex_y    = vy_q;
	assign vertex_z    = vz_q;
	assign out_red     = or_out_q;
	assign out_green   = og_out_q;
	assign out_blue    = ob_out_q;
	assign out_alpha   = oa_out_q;
	assign tex_u       = u_q;
	assign tex_v       = v_q;
	assign last_vertex = last_q;
endmodule

/* rtl/slqe_mul.sv */
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on nothing but the clock.
module slqe_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p
);
	logic [63:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= {32'b0, a} * {32'b0, b};
	end

	assign p = p_q;
endmodule

/* rtl/slqe_iter.sv */
// Bit-serial unit: restoring square root (32 steps) or division (31 steps).
// One shared compare/subtract serves both; uses slqe_pkg.
module slqe_iter (
	input  logic                  clk,
	input  logic                  arst_n,
	input  slqe_pkg::iter_cmd_t   cmd,
	input  logic [63:0]           opnd,
	input  logic [31:0]           dvs,
	output logic                  done,
	output logic [31:0]           res
);
	import slqe_pkg::*;

	logic        run_q, done_q;
	logic [5:0]  cnt_q;
	iter_mode_t  mode_q;
	logic [33:0] rem_q;
	logic [31:0] res_q, dvs_q;
	logic [63:0] src_q;

	logic [35:0] rem_sh, sub;
	logic [36:0] diff;
	logic        ge;

	always_comb begin
		if (mode_q == IT_SQRT) begin
			rem_sh = {rem_q, src_q[63:62]};
			sub    = {2'b0, res_q, 2'b01};
		end else begin
			rem_sh = {1'b0, rem_q, src_q[63]};
			sub    = {4'b0, dvs_q};
		end
		diff = {1'b0, rem_sh} - {1'b0, sub};
		ge   = ~diff[36];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				run_q <= 1'b1;
				cnt_q <= (cmd.mode == IT_SQRT) ? 6'd32 : 6'd31;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q <= cmd.mode;
			res_q  <= '0;
			dvs_q  <= dvs;
			if (cmd.mode == IT_SQRT) begin
				rem_q <= '0;
				src_q <= opnd;
			end else begin
				rem_q <= {3'b0, opnd[61:31]};
				src_q <= {opnd[30:0], 33'b0};
			end
		end else if (run_q) begin
			rem_q <= ge ? diff[33:0] : rem_sh[33:0];
			res_q <= {res_q[30:0], ge};
			src_q <= (mode_q == IT_SQRT) ? {src_q[61:0], 2'b0} : {src_q[62:0], 1'b0};
		end
	end

	assign done = done_q;
	assign res  = res_q;
endmodule
